// ===== design/tcpft_pkg.sv =====
// shared types and constants of the tcp flow tracker
`timescale 1ns / 1ps
`default_nettype none
package tcpft_pkg;
    localparam int FLOW_ENTRIES   = 32;
    localparam int IDX_W          = $clog2(FLOW_ENTRIES);
    localparam int CNT_W          = $clog2(FLOW_ENTRIES + 1);
    localparam int MAX_FLOW_BYTES = 8192;
    localparam int BYTE_W         = 14;
    localparam int OUT_BYTE_W     = 17;
    localparam int PLEN_W         = 18;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [15:0] PORT_TELNET  = 16'd23;
    localparam logic [15:0] PORT_FTP     = 16'd21;
    localparam logic [15:0] PORT_RLOGIN  = 16'd513;
    localparam logic [15:0] PORT_SMTP    = 16'd25;

    localparam logic [1:0] REG_EXCLUDE = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [1:0] RSN_LIMIT = 2'd0;
    localparam logic [1:0] RSN_FIN   = 2'd1;
    localparam logic [1:0] RSN_RST   = 2'd2;
    localparam logic [1:0] RSN_IDLE  = 2'd3;

    typedef struct packed {
        logic [31:0]              src_ip;
        logic [31:0]              dst_ip;
        logic [15:0]              src_port;
        logic [15:0]              dst_port;
        logic                     fin;
        logic                     syn;
        logic                     rst;
        logic signed [PLEN_W-1:0] plen;
        logic [31:0]              now;
    } pkt_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_limit;
        logic [15:0]       flow_timeout;
    } cfg_t;

    typedef struct packed {
        logic [31:0]       src_ip;
        logic [31:0]       dst_ip;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [31:0]       start;
        logic [BYTE_W-1:0] bytes;
        logic [31:0]       packets;
    } flow_t;

    typedef struct packed {
        logic [31:0]           src_ip;
        logic [31:0]           dst_ip;
        logic [15:0]           src_port;
        logic [15:0]           dst_port;
        logic [31:0]           packets;
        logic [OUT_BYTE_W-1:0] bytes;
        logic [1:0]            reason;
    } close_t;
endpackage
`default_nettype wire

// ===== design/tcpft_front.sv =====
// front end: configuration registers, packet filter and payload length
`timescale 1ns / 1ps
`default_nettype none
module tcpft_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              accept,
    input  wire logic [15:0]       eth_type,
    input  wire logic [7:0]        ip_proto,
    input  wire logic [31:0]       src_ip,
    input  wire logic [31:0]       dst_ip,
    input  wire logic [15:0]       src_port,
    input  wire logic [15:0]       dst_port,
    input  wire logic [5:0]        tcp_flags,
    input  wire logic [15:0]       ip_total_len,
    input  wire logic [3:0]        ip_hdr_words,
    input  wire logic [3:0]        tcp_hdr_words,
    input  wire logic [31:0]       now_seconds,
    output logic                   push,
    output tcpft_pkg::pkt_t        pkt,
    output tcpft_pkg::cfg_t        cfg
);
    logic [3:0]                   excl_reg;
    logic [tcpft_pkg::BYTE_W-1:0] limit_reg;
    logic [15:0]                  tmo_reg;
    logic                         svc_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            excl_reg  <= 4'd0;
            limit_reg <= tcpft_pkg::BYTE_W'(128);
            tmo_reg   <= 16'd1800;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcpft_pkg::REG_EXCLUDE: excl_reg <= cfg_data[3:0];
                tcpft_pkg::REG_LIMIT:
                begin
                    if (cfg_data[13:0] > 14'(tcpft_pkg::MAX_FLOW_BYTES))
                        limit_reg <= tcpft_pkg::BYTE_W'(tcpft_pkg::MAX_FLOW_BYTES);
                    else
                        limit_reg <= cfg_data[13:0];
                end
                tcpft_pkg::REG_TIMEOUT: tmo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (dst_port)
            tcpft_pkg::PORT_TELNET: svc_ok = !excl_reg[0];
            tcpft_pkg::PORT_FTP:    svc_ok = !excl_reg[1];
            tcpft_pkg::PORT_RLOGIN: svc_ok = !excl_reg[2];
            tcpft_pkg::PORT_SMTP:   svc_ok = !excl_reg[3];
            default:                svc_ok = 1'b0;
        endcase
    end

    assign push = accept && svc_ok && (eth_type == tcpft_pkg::ETYPE_IPV4)
                  && (ip_proto == tcpft_pkg::PROTO_TCP);

    always_comb
    begin
        pkt.src_ip   = src_ip;
        pkt.dst_ip   = dst_ip;
        pkt.src_port = src_port;
        pkt.dst_port = dst_port;
        pkt.fin      = tcp_flags[0];
        pkt.syn      = tcp_flags[1];
        pkt.rst      = tcp_flags[2];
        pkt.now      = now_seconds;
        // header words are at most 15, so the lengths fit in six bits each
        pkt.plen     = $signed({2'b00, ip_total_len})
                       - $signed({12'd0, ip_hdr_words, 2'b00})
                       - $signed({12'd0, tcp_hdr_words, 2'b00});
    end

    assign cfg.byte_limit   = limit_reg;
    assign cfg.flow_timeout = tmo_reg;
endmodule
`default_nettype wire

// ===== design/tcpft_fifo.sv =====
// two-entry queue of classified packets between front and back
`timescale 1ns / 1ps
`default_nettype none
module tcpft_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  tcpft_pkg::pkt_t      din,
    input  wire logic            pop,
    output logic                 not_empty,
    output tcpft_pkg::pkt_t      dout
);
    tcpft_pkg::pkt_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign not_empty = (cnt_reg != 2'd0);
    assign dout      = mem_reg[rp_reg];
endmodule
`default_nettype wire

// ===== design/tcpft_back.sv =====
// back end: flow table, lookup scan, update, idle sweep and result output
`timescale 1ns / 1ps
`default_nettype none
module tcpft_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  tcpft_pkg::cfg_t      cfg,
    input  wire logic            q_valid,
    input  tcpft_pkg::pkt_t      q_pkt,
    output logic                 pop,
    output logic                 active,
    output logic                 res_valid,
    output tcpft_pkg::close_t    res,
    output logic                 res_last
);
    localparam int N = tcpft_pkg::FLOW_ENTRIES;
    localparam int IW = tcpft_pkg::IDX_W;
    localparam int CW = tcpft_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_HIT   = 3'd2;
    localparam logic [2:0] S_SWST  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    tcpft_pkg::flow_t mem [N];
    tcpft_pkg::flow_t rdata_reg;

    logic [2:0]    state_reg, state_next;
    tcpft_pkg::pkt_t pkt_reg;
    logic [N-1:0]  valid_reg, valid_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pvld_reg, pvld_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic          ffound_reg, ffound_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [31:0]   sweep_reg, sweep_next;
    logic [31:0]   thr_reg, thr_next;

    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    tcpft_pkg::flow_t wr_data;

    logic              emit;
    tcpft_pkg::close_t emit_data;
    logic              flush;
    logic              pend_vld_reg;
    tcpft_pkg::close_t pend_reg;
    logic              out_vld_reg, out_last_reg;
    tcpft_pkg::close_t out_reg;

    logic          match, last_idx, free_here;
    logic [31:0]   pk_inc;
    logic          plen_pos;
    logic [tcpft_pkg::OUT_BYTE_W-1:0] sum;
    logic          under;
    logic [tcpft_pkg::BYTE_W-1:0] open_bytes;
    logic [32:0]   nx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[scan_reg[IW-1:0]];
    end

    assign match = valid_reg[pidx_reg]
                   && rdata_reg.src_ip == pkt_reg.src_ip
                   && rdata_reg.dst_ip == pkt_reg.dst_ip
                   && rdata_reg.src_port == pkt_reg.src_port
                   && rdata_reg.dst_port == pkt_reg.dst_port;
    assign last_idx  = (pidx_reg == IW'(N - 1));
    assign free_here = !valid_reg[pidx_reg];

    assign pk_inc   = (rdata_reg.packets == 32'hFFFF_FFFF) ? rdata_reg.packets
                      : rdata_reg.packets + 32'd1;
    assign plen_pos = (pkt_reg.plen > $signed(tcpft_pkg::PLEN_W'(0)));
    assign sum      = {3'b000, rdata_reg.bytes} + pkt_reg.plen[tcpft_pkg::OUT_BYTE_W-1:0];
    assign under    = (sum < {3'b000, cfg.byte_limit});
    assign nx       = {1'b0, pkt_reg.now} + {17'd0, cfg.flow_timeout};

    always_comb
    begin
        if (!plen_pos)
            open_bytes = '0;
        else if (pkt_reg.plen > $signed(tcpft_pkg::PLEN_W'(tcpft_pkg::MAX_FLOW_BYTES)))
            open_bytes = tcpft_pkg::BYTE_W'(tcpft_pkg::MAX_FLOW_BYTES);
        else
            open_bytes = pkt_reg.plen[tcpft_pkg::BYTE_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        scan_next   = scan_reg;
        pvld_next   = 1'b0;
        pidx_next   = pidx_reg;
        hit_next    = hit_reg;
        ffound_next = ffound_reg;
        fidx_next   = fidx_reg;
        sweep_next  = sweep_reg;
        thr_next    = thr_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = hit_reg;
        wr_data     = rdata_reg;
        emit        = 1'b0;
        emit_data.src_ip   = rdata_reg.src_ip;
        emit_data.dst_ip   = rdata_reg.dst_ip;
        emit_data.src_port = rdata_reg.src_port;
        emit_data.dst_port = rdata_reg.dst_port;
        emit_data.packets  = rdata_reg.packets;
        emit_data.bytes    = {3'b000, rdata_reg.bytes};
        emit_data.reason   = tcpft_pkg::RSN_IDLE;
        flush       = 1'b0;
        pop         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    scan_next   = '0;
                    ffound_next = 1'b0;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (pvld_reg && match)
                begin
                    hit_next   = pidx_reg;
                    state_next = S_HIT;
                end
                else
                begin
                    if (scan_reg < CW'(N))
                    begin
                        rd_en     = 1'b1;
                        scan_next = scan_reg + CW'(1);
                        pvld_next = 1'b1;
                        pidx_next = scan_reg[IW-1:0];
                    end
                    if (pvld_reg && free_here && !ffound_reg)
                    begin
                        ffound_next = 1'b1;
                        fidx_next   = pidx_reg;
                    end
                    if (pvld_reg && last_idx)
                    begin
                        // miss: a syn takes the lowest free entry
                        if (pkt_reg.syn && (ffound_reg || free_here))
                        begin
                            wr_en            = 1'b1;
                            wr_idx           = ffound_reg ? fidx_reg : pidx_reg;
                            wr_data.src_ip   = pkt_reg.src_ip;
                            wr_data.dst_ip   = pkt_reg.dst_ip;
                            wr_data.src_port = pkt_reg.src_port;
                            wr_data.dst_port = pkt_reg.dst_port;
                            wr_data.start    = pkt_reg.now;
                            wr_data.bytes    = open_bytes;
                            wr_data.packets  = 32'd1;
                            valid_next[wr_idx] = 1'b1;
                        end
                        pvld_next  = 1'b0;
                        state_next = S_SWST;
                    end
                end
            end
            S_HIT:
            begin
                wr_en           = 1'b1;
                wr_data.packets = pk_inc;
                emit_data.packets = pk_inc;
                if (plen_pos && under)
                    wr_data.bytes = sum[tcpft_pkg::BYTE_W-1:0];
                if (plen_pos && !under)
                begin
                    emit             = 1'b1;
                    emit_data.bytes  = sum;
                    emit_data.reason = tcpft_pkg::RSN_LIMIT;
                end
                else if (pkt_reg.fin || pkt_reg.rst)
                begin
                    emit             = 1'b1;
                    emit_data.bytes  = {3'b000, wr_data.bytes};
                    emit_data.reason = pkt_reg.fin ? tcpft_pkg::RSN_FIN : tcpft_pkg::RSN_RST;
                end
                if (emit)
                    valid_next[hit_reg] = 1'b0;
                state_next = S_SWST;
            end
            S_SWST:
            begin
                state_next = S_DONE;
                if (sweep_reg < pkt_reg.now)
                begin
                    sweep_next = nx[32] ? 32'hFFFF_FFFF : nx[31:0];
                    if (pkt_reg.now >= {16'd0, cfg.flow_timeout})
                    begin
                        thr_next   = pkt_reg.now - {16'd0, cfg.flow_timeout};
                        scan_next  = '0;
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (scan_reg < CW'(N))
                begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + CW'(1);
                    pvld_next = 1'b1;
                    pidx_next = scan_reg[IW-1:0];
                end
                if (pvld_reg && valid_reg[pidx_reg] && rdata_reg.start < thr_reg)
                begin
                    emit                 = 1'b1;
                    valid_next[pidx_reg] = 1'b0;
                end
                if (pvld_reg && last_idx)
                begin
                    pvld_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                flush      = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            scan_reg     <= '0;
            pvld_reg     <= 1'b0;
            pidx_reg     <= '0;
            hit_reg      <= '0;
            ffound_reg   <= 1'b0;
            fidx_reg     <= '0;
            sweep_reg    <= 32'd0;
            thr_reg      <= 32'd0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            scan_reg   <= scan_next;
            pvld_reg   <= pvld_next;
            pidx_reg   <= pidx_next;
            hit_reg    <= hit_next;
            ffound_reg <= ffound_next;
            fidx_reg   <= fidx_next;
            sweep_reg  <= sweep_next;
            thr_reg    <= thr_next;
            // one close is held back until we know whether it is the final one
            out_vld_reg  <= pend_vld_reg && (emit || flush);
            out_last_reg <= flush;
            if (emit)
                pend_vld_reg <= 1'b1;
            else if (flush)
                pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
            pkt_reg <= q_pkt;
        if (emit || flush)
            out_reg <= pend_reg;
        if (emit)
            pend_reg <= emit_data;
    end

    assign active    = (state_reg != S_IDLE);
    assign res_valid = out_vld_reg;
    assign res       = out_reg;
    assign res_last  = out_last_reg;
endmodule
`default_nettype wire

// ===== design/tcp_flow_tracker_unit.sv =====
// top level of the tcp flow tracker
// a kept packet is looked up one table entry a cycle, up to the first match; a hit is
// updated, then a sweep may rescan all 32 entries, both via the single table read port;
// busy rises at the accepting edge and stays high until the item is done; a filtered packet
// leaves it low; each close shows in the cycle after the next is found, the final one in the
// first cycle with busy low. reset clears valid bits and sweep time and sets config defaults
`timescale 1ns / 1ps
`default_nettype none
module tcp_flow_tracker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] eth_type,
    input  wire logic [7:0]  ip_proto,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [5:0]  tcp_flags,
    input  wire logic [15:0] ip_total_len,
    input  wire logic [3:0]  ip_hdr_words,
    input  wire logic [3:0]  tcp_hdr_words,
    input  wire logic [31:0] now_seconds,
    output logic             result_valid,
    output logic [31:0]      end_src_ip,
    output logic [31:0]      end_dst_ip,
    output logic [15:0]      end_src_port,
    output logic [15:0]      end_dst_port,
    output logic [31:0]      end_packets,
    output logic [16:0]      end_bytes,
    output logic [1:0]       end_reason,
    output logic             last
);
    logic              push, q_valid, pop, active;
    tcpft_pkg::pkt_t   pkt, q_pkt;
    tcpft_pkg::cfg_t   cfg;
    tcpft_pkg::close_t res;

    tcpft_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .accept(start && !busy),
        .eth_type(eth_type), .ip_proto(ip_proto),
        .src_ip(src_ip), .dst_ip(dst_ip),
        .src_port(src_port), .dst_port(dst_port),
        .tcp_flags(tcp_flags), .ip_total_len(ip_total_len),
        .ip_hdr_words(ip_hdr_words), .tcp_hdr_words(tcp_hdr_words),
        .now_seconds(now_seconds),
        .push(push), .pkt(pkt), .cfg(cfg)
    );

    tcpft_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .din(pkt),
        .pop(pop), .not_empty(q_valid), .dout(q_pkt)
    );

    tcpft_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_pkt(q_pkt), .pop(pop), .active(active),
        .res_valid(result_valid), .res(res), .res_last(last)
    );

    assign busy         = q_valid || active;
    assign end_src_ip   = res.src_ip;
    assign end_dst_ip   = res.dst_ip;
    assign end_src_port = res.src_port;
    assign end_dst_port = res.dst_port;
    assign end_packets  = res.packets;
    assign end_bytes    = res.bytes;
    assign end_reason   = res.reason;
endmodule
`default_nettype wire

// ===== design/tcpft_checker.sv =====
// port-level checks of the tcp flow tracker and their bind
`timescale 1ns / 1ps
`default_nettype none
module tcpft_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        result_valid,
    input wire logic        last,
    input wire logic [31:0] end_packets
);
    // every close belongs to an item still in work
    a_res_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("close beat without an item in work");

    // the final close of an item is not followed straight away by another
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("close beat right after the final one");

    // an open flow has always counted at least its opening packet
    a_packets: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> end_packets != 32'd0)
        else $error("closed flow with no packets");
endmodule

bind tcp_flow_tracker_unit tcpft_checker u_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .result_valid(result_valid),
    .last(last), .end_packets(end_packets)
);
`default_nettype wire
